@@ rtl/core/cnad_pkg.sv @@
// ----------------------------------------------------------------------------
// cnad_pkg
// Shared types, register map and calendar helpers for the next alarm date
// search block.
// ----------------------------------------------------------------------------
package cnad_pkg;

  // field widths
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MONTH_MASK   = 3'd0;
  localparam logic [2:0] REG_DAY_MASK     = 3'd1;
  localparam logic [2:0] REG_ALARM_HOUR   = 3'd2;
  localparam logic [2:0] REG_ALARM_MINUTE = 3'd3;
  localparam logic [2:0] REG_FIRST_YEAR   = 3'd4;
  localparam logic [2:0] REG_FIRST_MONTH  = 3'd5;
  localparam logic [2:0] REG_FIRST_DAY    = 3'd6;

  // reciprocal for divide by 100: q = (y * 5243) >> 19, exact below 43699
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  // days per month, february as in a common year
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // configuration register set
  typedef struct packed {
    logic [11:0]       month_mask;
    logic [30:0]       day_mask;
    logic [HOUR_W-1:0] alarm_hour;
    logic [MIN_W-1:0]  alarm_minute;
    logic [YEAR_W-1:0] first_year;
    logic [MON_W-1:0]  first_month;
    logic [DAY_W-1:0]  first_day;
  } cnad_cfg_t;

  // current instant of one query
  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } cnad_now_t;

  // length of a month in the range 1 to 12
  function automatic logic [4:0] days_in(input logic [MON_W-1:0] mon, input logic leap);
    logic [MON_W-1:0] idx;
    idx = mon - 4'd1;
    if (mon == 4'd2) begin
      days_in = leap ? 5'd29 : 5'd28;
    end else begin
      days_in = MONTH_LEN[idx];
    end
  endfunction

endpackage

@@ rtl/core/cnad_regs.sv @@
// ----------------------------------------------------------------------------
// cnad_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module cnad_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output cnad_pkg::cnad_cfg_t  cfg
);

  cnad_pkg::cnad_cfg_t cfg_r;
  logic                wr_en;
  logic [2:0]          reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.month_mask   <= '0;
      cfg_r.day_mask     <= '0;
      cfg_r.alarm_hour   <= '0;
      cfg_r.alarm_minute <= '0;
      cfg_r.first_year   <= 14'd1970;
      cfg_r.first_month  <= 4'd1;
      cfg_r.first_day    <= 5'd1;
    end else if (wr_en) begin
      case (reg_idx)
        cnad_pkg::REG_MONTH_MASK:   cfg_r.month_mask   <= cfg_pwdata[11:0];
        cnad_pkg::REG_DAY_MASK:     cfg_r.day_mask     <= cfg_pwdata[30:0];
        cnad_pkg::REG_ALARM_HOUR:   cfg_r.alarm_hour   <= cfg_pwdata[4:0];
        cnad_pkg::REG_ALARM_MINUTE: cfg_r.alarm_minute <= cfg_pwdata[5:0];
        cnad_pkg::REG_FIRST_YEAR:   cfg_r.first_year   <= cfg_pwdata[13:0];
        cnad_pkg::REG_FIRST_MONTH:  cfg_r.first_month  <= cfg_pwdata[3:0];
        cnad_pkg::REG_FIRST_DAY:    cfg_r.first_day    <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      cnad_pkg::REG_MONTH_MASK:   cfg_prdata = {20'd0, cfg_r.month_mask};
      cnad_pkg::REG_DAY_MASK:     cfg_prdata = {1'b0, cfg_r.day_mask};
      cnad_pkg::REG_ALARM_HOUR:   cfg_prdata = {27'd0, cfg_r.alarm_hour};
      cnad_pkg::REG_ALARM_MINUTE: cfg_prdata = {26'd0, cfg_r.alarm_minute};
      cnad_pkg::REG_FIRST_YEAR:   cfg_prdata = {18'd0, cfg_r.first_year};
      cnad_pkg::REG_FIRST_MONTH:  cfg_prdata = {28'd0, cfg_r.first_month};
      cnad_pkg::REG_FIRST_DAY:    cfg_prdata = {27'd0, cfg_r.first_day};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/cnad_month_unit.sv @@
// ----------------------------------------------------------------------------
// cnad_month_unit
// Evaluates one candidate month: finds the first repeating day that exists
// in the month and lies strictly after the current instant.
// ----------------------------------------------------------------------------
module cnad_month_unit (
  input  cnad_pkg::cnad_cfg_t  cfg,
  input  cnad_pkg::cnad_now_t  now,
  input  logic [14:0]          year,
  input  logic [3:0]           mon,
  input  logic                 leap,
  output logic                 hit,
  output logic [4:0]           day
);

  logic [3:0]  mon_idx;
  logic        mon_sel;
  logic        ym_gt;
  logic        ym_eq;
  logic        time_gt;
  logic [4:0]  nd_max;
  logic [30:0] exist_mask;
  logic [31:0] above_now;
  logic [30:0] after_mask;
  logic [30:0] cand;

  // month enabled in the repeat mask
  assign mon_idx = mon - 4'd1;
  assign mon_sel = cfg.month_mask[mon_idx];

  // year/month order against now
  assign ym_gt   = {year, mon} > {1'b0, now.year, now.month};
  assign ym_eq   = {year, mon} == {1'b0, now.year, now.month};
  assign time_gt = {cfg.alarm_hour, cfg.alarm_minute} > {now.hour, now.minute};

  // days that exist in this month
  assign nd_max     = cnad_pkg::days_in(mon, leap);
  assign exist_mask = 31'h7FFF_FFFF >> (5'd31 - nd_max);

  // days strictly after now within the current month
  assign above_now = ~((32'd1 << now.day) - 32'd1);

  always_comb begin
    if (ym_gt) begin
      after_mask = '1;
    end else if (ym_eq) begin
      after_mask = above_now[30:0];
      if (time_gt && now.day != 5'd0) begin
        after_mask[now.day - 5'd1] = 1'b1;
      end
    end else begin
      after_mask = '0;
    end
  end

  assign cand = cfg.day_mask & exist_mask & after_mask;

  // lowest candidate day
  always_comb begin
    day = 5'd0;
    for (int i = 30; i >= 0; i--) begin
      if (cand[i]) begin
        day = 5'(i + 1);
      end
    end
  end

  assign hit = mon_sel & (|cand);

endmodule

@@ rtl/core/calendar_next_alarm_date_search.sv @@
// ----------------------------------------------------------------------------
// calendar_next_alarm_date_search
// Finds the next alarm instant from a month/day repeat mask or a one-shot
// date. A sequencer drives a shared month evaluation unit, one month a cycle.
// ----------------------------------------------------------------------------
// sequence: repeat mode passes S_Q0, S_Q1 and S_Q2 (leap-year work for this
//   and next year), then scans one month per S_SCAN step, 13 months at most;
//   one-shot mode passes S_ONE, then presents the result beat in S_OUT
// throughput: one query at a time, the next beat is taken after the result
//   beat leaves
// reset: synchronous active-low rst_n clears the sequencer and restores the
//   register reset values; no clearing pass
module calendar_next_alarm_date_search (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // now_year, now_month, now_day, now_hour, now_minute
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // next_year, next_month, next_day, next_hour, next_minute
  output logic        out_tuser,  // found
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_Q0,
    S_Q1,
    S_Q2,
    S_SCAN,
    S_OUT
  } state_t;

  state_t              state_r;
  cnad_pkg::cnad_cfg_t cfg;
  cnad_pkg::cnad_now_t now_in;
  cnad_pkg::cnad_now_t now_r;
  logic [3:0]          mon_r;
  logic                wrap_r;
  logic [3:0]          cnt_r;
  logic [7:0]          q_r;
  logic                leap0_r;
  logic                leap1_r;
  logic                found_r;
  logic [13:0]         ry_r;
  logic [3:0]          rm_r;
  logic [4:0]          rd_r;
  logic                out_valid_r;

  logic                in_acc;
  logic                out_acc;
  logic                repeat_mode;
  logic [3:0]          start_mon;
  logic [14:0]         ny_next;
  logic [14:0]         div_year;
  logic [27:0]         div_prod;
  logic [14:0]         q_times_100;
  logic [14:0]         leap_year;
  logic                div100;
  logic                leap_now;
  logic [14:0]         scan_year;
  logic                scan_leap;
  logic                unit_hit;
  logic [4:0]          unit_day;
  logic                one_gt;

  // configuration registers
  cnad_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // unpack input beat
  assign now_in.year   = in_tdata[13:0];
  assign now_in.month  = in_tdata[17:14];
  assign now_in.day    = in_tdata[22:18];
  assign now_in.hour   = in_tdata[27:23];
  assign now_in.minute = in_tdata[33:28];

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_acc    = out_valid_r & out_tready;

  assign repeat_mode = (cfg.month_mask != 12'd0) && (cfg.day_mask != 31'd0);

  // clamp the scan start into january..december
  always_comb begin
    if (now_in.month == 4'd0) begin
      start_mon = 4'd1;
    end else if (now_in.month > 4'd12) begin
      start_mon = 4'd12;
    end else begin
      start_mon = now_in.month;
    end
  end

  // shared divide-by-100 multiplier, this year then next year
  assign ny_next     = {1'b0, now_r.year} + 15'd1;
  assign div_year    = (state_r == S_Q0) ? {1'b0, now_r.year} : ny_next;
  assign div_prod    = {13'd0, div_year} * {15'd0, cnad_pkg::DIV100_MUL};
  assign q_times_100 = {7'd0, q_r} * 15'd100;
  // leap test on the year whose quotient sits in q_r
  assign leap_year   = (state_r == S_Q2) ? ny_next : {1'b0, now_r.year};
  assign div100      = (leap_year == q_times_100);
  assign leap_now    = ((leap_year[1:0] == 2'd0) && !div100) || (div100 && q_r[1:0] == 2'd0);

  // month under test
  assign scan_year = wrap_r ? ny_next : {1'b0, now_r.year};
  assign scan_leap = wrap_r ? leap1_r : leap0_r;

  cnad_month_unit u_month (
    .cfg  (cfg),
    .now  (now_r),
    .year (scan_year),
    .mon  (mon_r),
    .leap (scan_leap),
    .hit  (unit_hit),
    .day  (unit_day)
  );

  // one-shot date against now
  assign one_gt = {cfg.first_year, cfg.first_month, cfg.first_day,
                   cfg.alarm_hour, cfg.alarm_minute} >
                  {now_r.year, now_r.month, now_r.day, now_r.hour, now_r.minute};

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      ry_r        <= '0;
      rm_r        <= '0;
      rd_r        <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r  <= now_in;
            mon_r  <= start_mon;
            wrap_r <= 1'b0;
            cnt_r  <= 4'd0;
            state_r <= repeat_mode ? S_Q0 : S_ONE;
          end
        end
        S_ONE: begin
          found_r     <= one_gt;
          ry_r        <= one_gt ? cfg.first_year : 14'd0;
          rm_r        <= one_gt ? cfg.first_month : 4'd0;
          rd_r        <= one_gt ? cfg.first_day : 5'd0;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_Q0: begin
          q_r     <= div_prod[cnad_pkg::DIV100_SHIFT +: 8];
          state_r <= S_Q1;
        end
        S_Q1: begin
          leap0_r <= leap_now;
          q_r     <= div_prod[cnad_pkg::DIV100_SHIFT +: 8];
          state_r <= S_Q2;
        end
        S_Q2: begin
          leap1_r <= leap_now;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (unit_hit) begin
            found_r     <= 1'b1;
            ry_r        <= scan_year[13:0];
            rm_r        <= mon_r;
            rd_r        <= unit_day;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (cnt_r == 4'd12) begin
            found_r     <= 1'b0;
            ry_r        <= '0;
            rm_r        <= '0;
            rd_r        <= '0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 4'd1;
            if (mon_r == 4'd12) begin
              mon_r  <= 4'd1;
              wrap_r <= 1'b1;
            end else begin
              mon_r <= mon_r + 4'd1;
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  // pack result beat
  assign out_tuser = found_r;
  assign out_tdata = {6'd0, cfg.alarm_minute, cfg.alarm_hour, rd_r, rm_r, ry_r};

`ifndef SYNTH
  // never accepting while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // a miss reports a zero date
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (ry_r == 14'd0 && rm_r == 4'd0 && rd_r == 5'd0))
    else $error("miss with nonzero date");

  // a repeat hit lands on a real month and day
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && unit_hit) |=>
      (rm_r != 4'd0 && rm_r <= 4'd12 && rd_r != 5'd0))
    else $error("repeat hit outside calendar");

  // accepted query blocks further input next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("ready right after accept");
`endif

endmodule
